// ----- sv/stereo_vu_bargraph_slew_macros.svh -----
// Assertion macros shared by the stereo VU bargraph RTL.
// Included by svbs_row_gen, which has concurrent checks; no other dependencies.
`ifndef STEREO_VU_BARGRAPH_SLEW_MACROS_SVH
`define STEREO_VU_BARGRAPH_SLEW_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SVBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svbs assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SVBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svbs assertion failed");

`endif

// ----- sv/svbs_pkg.sv -----
// Package for the stereo VU bargraph: field widths, defaults, codes and the
// job record passed from the level front end to the row sequencer.
package svbs_pkg;

    // Parameter defaults
    localparam int LEVEL_MAX_DEF   = 100;
    localparam int BAR_ROWS_DEF    = 8;
    localparam int THRESH_ROWS_DEF = 8;
    localparam int SCREEN_ROWS_DEF = 24;

    // Field widths
    localparam int LEVEL_IN_W = 16;
    localparam int COORD_W    = 6;
    localparam int GLYPH_W    = 4;
    localparam int COLOR_W    = 2;
    localparam int STEP_W     = 8;
    localparam int THR_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Scaled level is at most 32 rows * 10 = 320
    localparam int SCALED_W = 9;

    localparam logic [GLYPH_W-1:0] GLYPH_FULL = 4'd10;

    // Register reset values
    localparam logic [STEP_W-1:0] RISE_RESET = 8'd20;
    localparam logic [STEP_W-1:0] FALL_RESET = 8'd10;
    localparam logic [THR_W-1:0]  WARN_RESET = 4'd5;
    localparam logic [THR_W-1:0]  CLIP_RESET = 4'd7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL = 2'd3;

    // Input opcodes
    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_NORMAL = 2'd0,
        COLOR_WARN   = 2'd1,
        COLOR_CLIP   = 2'd2
    } t_color;

    typedef struct packed {
        logic [SCALED_W-1:0] scaled_left;
        logic [SCALED_W-1:0] scaled_right;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  bottom_row;
    } t_job;

endpackage

// ----- sv/svbs_row_gen.sv -----
// Row sequencer: holds one draw job, registers one bar row per unstalled cycle.
// Depends on svbs_pkg and stereo_vu_bargraph_slew_macros.svh.
`include "stereo_vu_bargraph_slew_macros.svh"

module svbs_row_gen #(
    parameter int BAR_ROWS    = svbs_pkg::BAR_ROWS_DEF,
    parameter int THRESH_ROWS = svbs_pkg::THRESH_ROWS_DEF,
    parameter int SCREEN_ROWS = svbs_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  svbs_pkg::t_job                  i_job,
    input  logic [svbs_pkg::THR_W-1:0]      i_warn_level,
    input  logic [svbs_pkg::THR_W-1:0]      i_clip_level,
    output logic                            o_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [svbs_pkg::COORD_W-1:0]    o_screen_row,
    output logic [svbs_pkg::COORD_W-1:0]    o_column,
    output logic [svbs_pkg::GLYPH_W-1:0]    o_left_glyph,
    output logic [svbs_pkg::GLYPH_W-1:0]    o_right_glyph,
    output logic [svbs_pkg::COLOR_W-1:0]    o_row_color,
    output logic                            o_last
);

    localparam int IDX_W = (BAR_ROWS > 1) ? $clog2(BAR_ROWS) : 1;
    localparam int DW    = svbs_pkg::SCALED_W + 1;
    localparam int RW    = svbs_pkg::COORD_W + 1;

    // Threshold row per bar row, fixed at elaboration
    logic [svbs_pkg::THR_W-1:0] t_tab [BAR_ROWS];

    for (genvar g = 0; g < BAR_ROWS; g++) begin : g_thr
        localparam int TV = (g * THRESH_ROWS) / BAR_ROWS;
        assign t_tab[g] = svbs_pkg::THR_W'(TV);
    end

    logic                              r_job_valid;
    svbs_pkg::t_job                    r_job;
    logic [IDX_W-1:0]                  r_idx;

    logic                              r_out_valid;
    logic [svbs_pkg::COORD_W-1:0]      r_screen_row;
    logic [svbs_pkg::COORD_W-1:0]      r_column;
    logic [svbs_pkg::GLYPH_W-1:0]      r_left_glyph;
    logic [svbs_pkg::GLYPH_W-1:0]      r_right_glyph;
    svbs_pkg::t_color                  r_row_color;
    logic                              r_last;

    logic                              emit;
    logic                              row_last;
    logic [RW-1:0]                     row_sum;
    logic [DW-1:0]                     ten_row;
    logic [svbs_pkg::GLYPH_W-1:0]      n_left_glyph;
    logic [svbs_pkg::GLYPH_W-1:0]      n_right_glyph;
    logic [svbs_pkg::THR_W-1:0]        thr;
    svbs_pkg::t_color                  n_row_color;

    function automatic logic [svbs_pkg::GLYPH_W-1:0] fill(
        input logic [svbs_pkg::SCALED_W-1:0] sc,
        input logic [DW-1:0]                 base
    );
        logic [DW-1:0] d;
        d = DW'(sc) - base;
        if (DW'(sc) < base) begin
            return '0;
        end else if (d > DW'(svbs_pkg::GLYPH_FULL)) begin
            return svbs_pkg::GLYPH_FULL;
        end
        return d[svbs_pkg::GLYPH_W-1:0];
    endfunction

    always_comb begin
        emit     = r_job_valid && (!r_out_valid || !i_out_stall);
        row_sum  = RW'(r_job.bottom_row) + RW'(r_idx);
        // stop at the last bar row or at the top of the screen
        row_last = (r_idx == IDX_W'(BAR_ROWS - 1)) ||
                   ((row_sum + RW'(1)) >= RW'(SCREEN_ROWS));
        ten_row  = DW'(r_idx) * DW'(svbs_pkg::GLYPH_FULL);
        n_left_glyph  = fill(r_job.scaled_left, ten_row);
        n_right_glyph = fill(r_job.scaled_right, ten_row);
        thr = t_tab[r_idx];
        if (thr >= i_clip_level) begin
            n_row_color = svbs_pkg::COLOR_CLIP;
        end else if (thr > i_warn_level) begin
            n_row_color = svbs_pkg::COLOR_WARN;
        end else begin
            n_row_color = svbs_pkg::COLOR_NORMAL;
        end
    end

    assign o_ready = !r_job_valid || (emit && row_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_job_valid <= 1'b1;
                r_job       <= i_job;
                r_idx       <= '0;
            end else if (emit) begin
                if (row_last) begin
                    r_job_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            if (emit) begin
                r_out_valid   <= 1'b1;
                r_screen_row  <= row_sum[svbs_pkg::COORD_W-1:0];
                r_column      <= r_job.column;
                r_left_glyph  <= n_left_glyph;
                r_right_glyph <= n_right_glyph;
                r_row_color   <= n_row_color;
                r_last        <= row_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_screen_row  = r_screen_row;
    assign o_column      = r_column;
    assign o_left_glyph  = r_left_glyph;
    assign o_right_glyph = r_right_glyph;
    assign o_row_color   = svbs_pkg::COLOR_W'(r_row_color);
    assign o_last        = r_last;

    `SVBS_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_load, (!r_job_valid || (emit && row_last)))
    `SVBS_ASSERT_NXT(a_job_held, i_clk, i_rst_n, r_job_valid && !row_last && !i_load, r_job_valid && $stable(r_job))
    `SVBS_ASSERT_IMP(a_row_on_screen, i_clk, i_rst_n, r_out_valid, RW'(r_screen_row) < RW'(SCREEN_ROWS))
    `SVBS_ASSERT_IMP(a_glyph_range, i_clk, i_rst_n, r_out_valid, (r_left_glyph <= svbs_pkg::GLYPH_FULL) && (r_right_glyph <= svbs_pkg::GLYPH_FULL))

endmodule

// ----- sv/stereo_vu_bargraph_slew.sv -----
// Stereo VU bargraph with attack/release slew limiting: top level.
// Depends on svbs_pkg and svbs_row_gen.
//
// A draw item is clamped, slew-limited against the stored levels and scaled
// in the cycle it is accepted; the row sequencer then puts out one bar row per
// cycle while the output is not stalled, for each row the item shows (up to
// BAR_ROWS, fewer near the top of the screen). The next item is taken in the
// same cycle the previous item's last row leaves the sequencer, and a reset
// item or a draw item with no row on screen does not load the sequencer. An
// accepted item is held in the job register and its rows pass through the
// output register. Configuration writes take effect at the next clock edge.
module stereo_vu_bargraph_slew #(
    parameter int LEVEL_MAX   = svbs_pkg::LEVEL_MAX_DEF,
    parameter int BAR_ROWS    = svbs_pkg::BAR_ROWS_DEF,
    parameter int THRESH_ROWS = svbs_pkg::THRESH_ROWS_DEF,
    parameter int SCREEN_ROWS = svbs_pkg::SCREEN_ROWS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [svbs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [svbs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_opcode,
    input  logic signed [svbs_pkg::LEVEL_IN_W-1:0] i_left_level,
    input  logic signed [svbs_pkg::LEVEL_IN_W-1:0] i_right_level,
    input  logic [svbs_pkg::COORD_W-1:0]          i_bar_column,
    input  logic [svbs_pkg::COORD_W-1:0]          i_bottom_row,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [svbs_pkg::COORD_W-1:0]          o_screen_row,
    output logic [svbs_pkg::COORD_W-1:0]          o_column,
    output logic [svbs_pkg::GLYPH_W-1:0]          o_left_glyph,
    output logic [svbs_pkg::GLYPH_W-1:0]          o_right_glyph,
    output logic [svbs_pkg::COLOR_W-1:0]          o_row_color,
    output logic                                  o_last
);

    localparam int LVL_W = $clog2(LEVEL_MAX + 1);
    localparam int SW    = ((LVL_W > svbs_pkg::STEP_W) ? LVL_W : svbs_pkg::STEP_W) + 1;
    localparam int IW    = svbs_pkg::LEVEL_IN_W - 1;
    // level * BAR_ROWS * 10 / LEVEL_MAX as one multiply by a rounded-up
    // reciprocal; 2^SHIFT >= (LEVEL_MAX+1)^2 keeps the floor exact.
    localparam int SHIFT = 2 * LVL_W;
    localparam longint unsigned SCALE_K = longint'(BAR_ROWS) * 10;
    localparam longint unsigned MUL =
        ((SCALE_K << SHIFT) + longint'(LEVEL_MAX) - 1) / longint'(LEVEL_MAX);
    localparam int MUL_W = $clog2(MUL + 1);
    localparam int P_W   = LVL_W + MUL_W;
    localparam int RW    = svbs_pkg::COORD_W + 1;

    logic [svbs_pkg::STEP_W-1:0] r_rise_step;
    logic [svbs_pkg::STEP_W-1:0] r_fall_step;
    logic [svbs_pkg::THR_W-1:0]  r_warn_level;
    logic [svbs_pkg::THR_W-1:0]  r_clip_level;
    logic [LVL_W-1:0]            r_prev_left;
    logic [LVL_W-1:0]            r_prev_right;

    logic                        ready;
    logic                        accept;
    logic                        load;
    logic [LVL_W-1:0]            n_left;
    logic [LVL_W-1:0]            n_right;
    svbs_pkg::t_job              job;

    function automatic logic [LVL_W-1:0] clamp_lvl(
        input logic signed [svbs_pkg::LEVEL_IN_W-1:0] req
    );
        if (req[svbs_pkg::LEVEL_IN_W-1]) begin
            return '0;
        end else if (req[IW-1:0] > IW'(LEVEL_MAX)) begin
            return LVL_W'(LEVEL_MAX);
        end
        return req[LVL_W-1:0];
    endfunction

    function automatic logic [LVL_W-1:0] slew(
        input logic [LVL_W-1:0]           v,
        input logic [LVL_W-1:0]           prev,
        input logic [svbs_pkg::STEP_W-1:0] rise,
        input logic [svbs_pkg::STEP_W-1:0] fall
    );
        logic [SW-1:0] up;
        logic [SW-1:0] dn;
        up = SW'(prev) + SW'(rise);
        dn = SW'(prev) - SW'(fall);
        if (SW'(v) > up) begin
            return up[LVL_W-1:0];
        end else if ((SW'(v) + SW'(fall)) < SW'(prev)) begin
            return dn[LVL_W-1:0];
        end
        return v;
    endfunction

    function automatic logic [svbs_pkg::SCALED_W-1:0] scale(input logic [LVL_W-1:0] lv);
        logic [P_W-1:0] p;
        p = P_W'(lv) * P_W'(MUL);
        return svbs_pkg::SCALED_W'(p >> SHIFT);
    endfunction

    always_comb begin
        accept  = i_in_valid && ready;
        n_left  = slew(clamp_lvl(i_left_level), r_prev_left, r_rise_step, r_fall_step);
        n_right = slew(clamp_lvl(i_right_level), r_prev_right, r_rise_step, r_fall_step);
        // a draw item whose first row is off screen only updates the levels
        load    = accept && (i_opcode == svbs_pkg::OP_DRAW) &&
                  (RW'(i_bottom_row) < RW'(SCREEN_ROWS));
        job.scaled_left  = scale(n_left);
        job.scaled_right = scale(n_right);
        job.column       = i_bar_column;
        job.bottom_row   = i_bottom_row;
    end

    assign o_in_stall = !ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_step  <= svbs_pkg::RISE_RESET;
            r_fall_step  <= svbs_pkg::FALL_RESET;
            r_warn_level <= svbs_pkg::WARN_RESET;
            r_clip_level <= svbs_pkg::CLIP_RESET;
            r_prev_left  <= '0;
            r_prev_right <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    svbs_pkg::CFG_RISE_STEP: begin
                        r_rise_step <= i_cfg_data;
                    end
                    svbs_pkg::CFG_FALL_STEP: begin
                        r_fall_step <= i_cfg_data;
                    end
                    svbs_pkg::CFG_WARN_LEVEL: begin
                        r_warn_level <= i_cfg_data[svbs_pkg::THR_W-1:0];
                    end
                    svbs_pkg::CFG_CLIP_LEVEL: begin
                        r_clip_level <= i_cfg_data[svbs_pkg::THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                if (i_opcode == svbs_pkg::OP_RESET) begin
                    r_prev_left  <= '0;
                    r_prev_right <= '0;
                end else begin
                    r_prev_left  <= n_left;
                    r_prev_right <= n_right;
                end
            end
        end
    end

    svbs_row_gen #(
        .BAR_ROWS    (BAR_ROWS),
        .THRESH_ROWS (THRESH_ROWS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_row_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_job         (job),
        .i_warn_level  (r_warn_level),
        .i_clip_level  (r_clip_level),
        .o_ready       (ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_screen_row  (o_screen_row),
        .o_column      (o_column),
        .o_left_glyph  (o_left_glyph),
        .o_right_glyph (o_right_glyph),
        .o_row_color   (o_row_color),
        .o_last        (o_last)
    );

endmodule
